>>> hw/rtl/lfp_pkg.sv
// Shared types and constants of the lidar frame parser.
// Used by lfp_front, lfp_queue, lfp_back and lidar_frame_parser.
package lfp_pkg;

  localparam logic [7:0] START_BYTE = 8'hFA;
  localparam logic [4:0] LAST_POS   = 5'd21;  // position of the checksum high byte
  localparam logic [4:0] FOLD_END   = 5'd20;  // words at positions below this are folded
  localparam logic [4:0] IDX_POS    = 5'd1;
  localparam logic [4:0] SPEED_POS  = 5'd3;
  localparam logic [8:0] INDEX_BASE = 9'd160;

  localparam int ANGLE_W = 11;
  localparam int DIST_W  = 14;
  localparam int RPM_W   = 10;
  localparam int ACC_W   = 26;
  localparam int SLOTS   = 4;

  typedef logic [1:0] slot_t;

  // One checked frame: everything the back end needs to emit four readings.
  typedef struct packed {
    logic [7:0]                     idx;
    logic [RPM_W-1:0]               rpm;
    logic [SLOTS-1:0][DIST_W-1:0]   dists;
  } frame_rec_t;

  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } push_req_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } q_status_t;

endpackage

>>> hw/rtl/lfp_front.sv
// Front end: frame sync, byte collection, checksum fold and check.
// Depends on lfp_pkg; pushes good frames toward lfp_queue.
module lfp_front import lfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  q_status_t  q_stat,
  output push_req_t  push_req
);

  logic                           in_frame_r, in_frame_nxt;
  logic [4:0]                     cnt_r, cnt_nxt;
  logic [7:0]                     prev_r;
  logic [ACC_W-1:0]               acc_r, acc_nxt;
  logic [7:0]                     idx_r, idx_nxt;
  logic [RPM_W-1:0]               rpm_r, rpm_nxt;
  logic [SLOTS-1:0][DIST_W-1:0]   dist_r, dist_nxt;

  logic        beat;
  logic        take;
  logic [4:0]  pos;
  logic [15:0] word;
  logic [ACC_W-1:0] acc_base;
  logic [15:0] folded;
  slot_t       slot;

  // Stall only on the closing byte while the queue has no room.
  assign in_tready = !(in_frame_r && (cnt_r == LAST_POS) && q_stat.full);
  assign beat      = in_tvalid && in_tready;
  assign take      = beat && (in_frame_r || (in_tdata == START_BYTE));
  assign pos       = in_frame_r ? cnt_r : 5'd0;
  assign word      = {in_tdata, prev_r};
  assign acc_base  = in_frame_r ? acc_r : '0;
  assign folded    = {1'b0, acc_r[14:0] + {4'd0, acc_r[ACC_W-1:15]}};
  assign slot      = slot_t'(pos[4:2] - 3'd1);

  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    idx_nxt      = idx_r;
    rpm_nxt      = rpm_r;
    dist_nxt     = dist_r;
    if (take) begin
      in_frame_nxt = 1'b1;
      cnt_nxt      = pos + 5'd1;
      acc_nxt      = acc_base;
      if (pos[0] && (pos < FOLD_END)) begin
        acc_nxt = ACC_W'({acc_base[ACC_W-2:0], 1'b0} + {10'd0, word});
      end
      if (pos == IDX_POS) begin
        idx_nxt = in_tdata;
      end
      if (pos == SPEED_POS) begin
        rpm_nxt = word[15:6];
      end
      if ((pos[1:0] == 2'b01) && (pos > SPEED_POS) && (pos < FOLD_END)) begin
        dist_nxt[slot] = word[15] ? '0 : word[DIST_W-1:0];
      end
      if (pos == LAST_POS) begin
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
      end
    end
  end

  always_comb begin
    push_req.push      = take && (pos == LAST_POS) && (folded == word);
    push_req.rec.idx   = idx_r;
    push_req.rec.rpm   = rpm_r;
    push_req.rec.dists = dist_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      acc_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
      acc_r      <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      prev_r <= in_tdata;
    end
    idx_r  <= idx_nxt;
    rpm_r  <= rpm_nxt;
    dist_r <= dist_nxt;
  end

endmodule

>>> hw/rtl/lfp_queue.sv
// Two-entry queue of checked frame records between front and back end.
// Depends on lfp_pkg.
module lfp_queue import lfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_req_t  push_req,
  input  logic       pop,
  output q_status_t  q_stat,
  output frame_rec_t head
);

  frame_rec_t  mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign do_push      = push_req.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req.rec;
    end
  end

endmodule

>>> hw/rtl/lfp_back.sv
// Back end: expands one frame record into four readings in an output register.
// Depends on lfp_pkg; reads the head of lfp_queue.
module lfp_back import lfp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  q_status_t           q_stat,
  input  frame_rec_t          head,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [ANGLE_W-1:0]  angle,
  output logic [DIST_W-1:0]   distance,
  output logic [RPM_W-1:0]    rpm,
  output logic                out_tlast
);

  slot_t               slot_r;
  logic                valid_r;
  logic [ANGLE_W-1:0]  angle_r;
  logic [DIST_W-1:0]   dist_r;
  logic [RPM_W-1:0]    rpm_r;
  logic                last_r;
  logic                load;
  logic [8:0]          base;

  assign load       = !q_stat.empty && (!valid_r || out_tready);
  assign pop        = load && (slot_r == slot_t'(SLOTS - 1));
  assign base       = {1'b0, head.idx} - INDEX_BASE;
  assign out_tvalid = valid_r;
  assign angle      = angle_r;
  assign distance   = dist_r;
  assign rpm        = rpm_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        slot_r  <= slot_r + slot_t'(1);
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      angle_r <= {base, slot_r};
      dist_r  <= head.dists[slot_r];
      rpm_r   <= head.rpm;
      last_r  <= (slot_r == slot_t'(SLOTS - 1));
    end
  end

endmodule

>>> hw/rtl/lidar_frame_parser.sv
// Top level of the lidar frame parser: front end, frame queue, back end.
// Depends on lfp_pkg, lfp_front, lfp_queue and lfp_back.
//
//  channel | ports       | tdata fields (low bit up)              | tlast
//  --------+-------------+----------------------------------------+--------------
//  input   | in_t*       | data_byte[7:0]                         | -
//  result  | out_t*      | angle[10:0] distance[24:11] rpm[34:25] | last_reading
//
// One byte is taken every cycle; the only input stall is on the closing byte
// of a frame, good or bad, while both queue entries are still held by the back end.
// A good frame is checked on its last byte and leaves four readings, one per
// cycle while out_tready is high, from the output register.
// Reset (rst_n low, synchronous) drops any partial frame and empties the queue.
// A stalled result holds in the output register while input bytes keep flowing.
module lidar_frame_parser import lfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [10:0] angle, [24:11] distance, [34:25] rpm, rest zero
  output logic        out_tlast
);

  push_req_t           push_req;
  q_status_t           q_stat;
  frame_rec_t          head;
  logic                pop;
  logic [ANGLE_W-1:0]  angle;
  logic [DIST_W-1:0]   distance;
  logic [RPM_W-1:0]    rpm;

  // Sync on the start byte, collect and check the frame.
  lfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push_req  (push_req)
  );

  // Hold checked frames so the two sides stall independently.
  lfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  // Emit four readings per frame.
  lfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .angle      (angle),
    .distance   (distance),
    .rpm        (rpm),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = {5'd0, rpm, distance, angle};

  // A frame is never pushed into a full queue: the front end stalls first.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_req.push && q_stat.full))
    else $error("frame pushed into full queue");

  // The marked reading is the fourth slot of its frame.
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[1:0] == 2'b11))
    else $error("last reading not in slot three");

  // A pop leaves the last reading of a frame in the output register.
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_tvalid && out_tlast))
    else $error("record popped before its last reading");

  // Input stalls only while the queue is full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_stat.full)
    else $error("input stalled with room in queue");

endmodule
